>>> sv/hnc_pkg.sv
// ----------------------------------------------------------------------------
// hnc_pkg
// Shared constants and types for the height map normal and colour pipeline.
// ----------------------------------------------------------------------------
package hnc_pkg;

   // Grid geometry
   localparam int GRID_VERTS = 128;
   localparam int MAP_W      = GRID_VERTS + 2;
   localparam int ADDR_W     = $clog2(MAP_W);

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int COORD_W  = 7;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int SQ_W     = 2 * SAMPLE_W;
   localparam int MAG_W    = 15;
   localparam int NORM_W   = 16;
   localparam int CLASS_W  = 3;
   localparam int TDATA_W  = 80;

   // Normalising search: one result bit per stage
   localparam int LANE_STEPS = MAG_W;
   localparam int S_W        = SQ_W + 2;
   localparam int R_W        = SQ_W + 30;
   localparam int ACC_W      = 72;

   // Y component before scaling: 2.0 in Q11.4, squared
   localparam logic [SQ_W-1:0] Y_SQ = SQ_W'(1024);
   localparam logic [MAG_W-1:0] UNIT_MAG = MAG_W'(16384);

   // Colour classes
   localparam logic [CLASS_W-1:0] CLASS_SNOW  = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_ROCK  = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_GRASS = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_SAND  = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_DEEP  = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_WATER = 3'd5;

   // Per-vertex data that travels beside the normal arithmetic
   typedef struct packed {
      logic [COORD_W-1:0]        col;
      logic [COORD_W-1:0]        row;
      logic signed [SAMPLE_W-1:0] height;
      logic [CLASS_W-1:0]        colour;
      logic                      last;
      logic                      water;
      logic                      neg_x;
      logic                      neg_z;
   } side_type;

endpackage

>>> sv/hnc_norm_lane.sv
// ----------------------------------------------------------------------------
// hnc_norm_lane
// Pipelined search for round(a * 16384 / sqrt(S)): one result bit per stage,
// using shifts and adds on (2m-1)^2 * S against a^2 * 2^30.
// ----------------------------------------------------------------------------
module hnc_norm_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [hnc_pkg::S_W-1:0]       s_in,
   input  logic [hnc_pkg::R_W-1:0]       r_in,
   output logic [hnc_pkg::MAG_W-1:0]     mag_out
);

   localparam int STEPS = hnc_pkg::LANE_STEPS;
   localparam int AW    = hnc_pkg::ACC_W;

   logic signed [AW-1:0]           e_ff  [STEPS];
   logic signed [AW-1:0]           us_ff [STEPS];
   logic [hnc_pkg::MAG_W-1:0]      m_ff  [STEPS];
   logic [hnc_pkg::S_W-1:0]        s_ff  [STEPS];
   logic [hnc_pkg::R_W-1:0]        r_ff  [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam int K = STEPS - 1 - i;
      logic signed [AW-1:0]      e_prev, us_prev, s_ext, r_ext, trial, e_in, us_in;
      logic [hnc_pkg::MAG_W-1:0] m_prev, m_in;
      logic [hnc_pkg::S_W-1:0]   s_prev;
      logic [hnc_pkg::R_W-1:0]   r_prev;
      logic                      take;

      // Start from m = 0, i.e. u = -1: u^2*S = S, u*S = -S
      if (i == 0) begin : g_first
         assign s_prev  = s_in;
         assign r_prev  = r_in;
         assign e_prev  = $signed({{(AW-hnc_pkg::S_W){1'b0}}, s_in});
         assign us_prev = -$signed({{(AW-hnc_pkg::S_W){1'b0}}, s_in});
         assign m_prev  = '0;
      end else begin : g_next
         assign s_prev  = s_ff[i-1];
         assign r_prev  = r_ff[i-1];
         assign e_prev  = e_ff[i-1];
         assign us_prev = us_ff[i-1];
         assign m_prev  = m_ff[i-1];
      end

      // Try setting bit K: (u + 2^(K+1))^2 * S <= a^2 * 2^30
      always_comb begin
         s_ext = $signed({{(AW-hnc_pkg::S_W){1'b0}}, s_prev});
         r_ext = $signed({{(AW-hnc_pkg::R_W){1'b0}}, r_prev});
         trial = e_prev + (us_prev <<< (K + 2)) + (s_ext <<< (2 * K + 2));
         take  = (trial <= r_ext);
         e_in  = take ? trial : e_prev;
         us_in = take ? (us_prev + (s_ext <<< (K + 1))) : us_prev;
         m_in  = take ? (m_prev | (hnc_pkg::MAG_W'(1) << K)) : m_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            e_ff[i]  <= e_in;
            us_ff[i] <= us_in;
            m_ff[i]  <= m_in;
            s_ff[i]  <= s_prev;
            r_ff[i]  <= r_prev;
         end
      end
   end

   assign mag_out = m_ff[STEPS-1];

endmodule

>>> sv/heightmap_normal_colour.sv
// Takes one signed Q11.4 height sample per cycle in raster order over a
// (GRID_VERTS+2)-square map with a one-point border, and gives one result per
// interior vertex: its height, a Q1.14 unit normal and a colour class. Results
// leave registered after the sample just below the vertex is transferred; the
// rate is one sample per cycle, set by the two simple dual-port line stores
// (one write and one registered read at another address each per sample) and
// by a 15-stage bit-per-stage normalising search. The whole pipeline stalls
// together when the result side holds tready low. water_mode may be written
// only while no vertex is in flight.
// ----------------------------------------------------------------------------
// heightmap_normal_colour
// Line-buffered central-difference normals and height colour classes.
// ----------------------------------------------------------------------------
module heightmap_normal_colour (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data,      // water_mode
   // height samples
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hnc_pkg::SAMPLE_W-1:0]    req_tdata,     // height_sample
   // vertex results
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // vertex_column[6:0], vertex_row[13:7], vertex_height[29:14],
   // normal_x[45:30], normal_y[60:46], normal_z[76:61], colour_class[79:77]
   output logic [hnc_pkg::TDATA_W-1:0]     rsp_tdata,
   output logic                            rsp_tlast      // last_vertex
);

   localparam int AW    = hnc_pkg::ADDR_W;
   localparam int SW    = hnc_pkg::SAMPLE_W;
   localparam int DW    = hnc_pkg::DIFF_W;
   localparam int QW    = hnc_pkg::SQ_W;
   localparam int STEPS = hnc_pkg::LANE_STEPS;
   localparam logic [AW-1:0] COL_LAST = AW'(hnc_pkg::MAP_W - 1);
   localparam logic [AW-1:0] COL_GRID = AW'(hnc_pkg::GRID_VERTS);
   localparam logic [AW-1:0] ROW_LAST = AW'(hnc_pkg::MAP_W - 1);

   logic en, accept;
   logic water_ff;

   // raster position and line stores
   logic [AW-1:0]  col_ff, row_ff;
   logic [SW-1:0]  older_mem [hnc_pkg::MAP_W];
   logic [SW-1:0]  newer_mem [hnc_pkg::MAP_W];
   logic [SW-1:0]  up_rd_ff, right_rd_ff;
   logic [SW-1:0]  cur_n_ff, left_ff, first_n_ff;
   logic [AW:0]    col_p1, col_p2;
   logic [AW-1:0]  up_addr, right_addr;
   logic           emit;

   // stage 1: stencil
   logic                      v1_ff;
   logic signed [SW-1:0]      c1_ff, l1_ff, r1_ff, u1_ff, d1_ff;
   hnc_pkg::side_type         side1_ff;
   // stage 2: differences
   logic                      v2_ff;
   logic [DW-1:0]             ax2_ff, az2_ff;
   hnc_pkg::side_type         side2_ff;
   logic signed [DW-1:0]      dx, dz;
   hnc_pkg::side_type         side2_in;
   // stage 3: squares
   logic                      v3_ff;
   logic [QW-1:0]             sx3_ff, sz3_ff;
   hnc_pkg::side_type         side3_ff;
   // stage 4: sum and targets
   logic                      v4_ff;
   logic [hnc_pkg::S_W-1:0]   s4_ff;
   logic [hnc_pkg::R_W-1:0]   rx4_ff, rz4_ff, ry4;
   hnc_pkg::side_type         side4_ff;
   // search side line
   logic                      vl_ff   [STEPS];
   hnc_pkg::side_type         sidel_ff [STEPS];
   logic [hnc_pkg::MAG_W-1:0] mag_x, mag_y, mag_z;
   // output register
   logic                      out_vld_ff;
   logic [hnc_pkg::TDATA_W-1:0] out_data_ff, out_data_in;
   logic                      out_last_ff;

   // Stall everything together while a result waits
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         water_ff <= 1'b0;
      end else if (csr_valid) begin
         water_ff <= csr_data;
      end
   end

   // Advance raster position
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_ff == COL_LAST) begin
            col_ff <= '0;
            row_ff <= (row_ff == ROW_LAST) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // Read ahead: older[c+1] and newer[c+2] (newer[1] at row end)
   always_comb begin
      col_p1 = {1'b0, col_ff} + 1'b1;
      col_p2 = {1'b0, col_ff} + 2'd2;
      up_addr = (col_p1 >= (AW+1)'(hnc_pkg::MAP_W)) ? '0 : col_p1[AW-1:0];
      if (col_ff == COL_LAST) begin
         right_addr = AW'(1);
      end else if (col_p2 >= (AW+1)'(hnc_pkg::MAP_W)) begin
         right_addr = '0;
      end else begin
         right_addr = col_p2[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         older_mem[col_ff] <= cur_n_ff;
         up_rd_ff          <= older_mem[up_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         newer_mem[col_ff] <= req_tdata;
         right_rd_ff       <= newer_mem[right_addr];
      end
   end

   // Hold the centre and left taps of the window
   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff  <= cur_n_ff;
         cur_n_ff <= (col_ff == COL_LAST) ? first_n_ff : right_rd_ff;
         if (col_ff == '0) begin
            first_n_ff <= req_tdata;
         end
      end
   end

   assign emit = (row_ff >= AW'(2)) && (col_ff != '0) && (col_ff <= COL_GRID);

   // Valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < STEPS; i++) begin
            vl_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff <= accept && emit;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vl_ff[0] <= v4_ff;
         for (int i = 1; i < STEPS; i++) begin
            vl_ff[i] <= vl_ff[i-1];
         end
         out_vld_ff <= vl_ff[STEPS-1];
      end
   end

   // Stage 1: capture the stencil
   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= cur_n_ff;
         l1_ff <= left_ff;
         r1_ff <= right_rd_ff;
         u1_ff <= up_rd_ff;
         d1_ff <= req_tdata;
         side1_ff.col    <= hnc_pkg::COORD_W'(col_ff - 1'b1);
         side1_ff.row    <= hnc_pkg::COORD_W'(row_ff - AW'(2));
         side1_ff.height <= cur_n_ff;
         side1_ff.colour <= hnc_pkg::CLASS_DEEP;
         side1_ff.last   <= (row_ff == ROW_LAST) && (col_ff == COL_GRID);
         side1_ff.water  <= water_ff;
         side1_ff.neg_x  <= 1'b0;
         side1_ff.neg_z  <= 1'b0;
      end
   end

   // Stage 2: differences, magnitudes and colour class
   always_comb begin
      dx       = DW'(l1_ff) - DW'(r1_ff);
      dz       = DW'(u1_ff) - DW'(d1_ff);
      side2_in = side1_ff;
      side2_in.neg_x = dx[DW-1];
      side2_in.neg_z = dz[DW-1];
      if (c1_ff >= SW'(176)) begin
         side2_in.colour = hnc_pkg::CLASS_SNOW;
      end else if (c1_ff >= SW'(112)) begin
         side2_in.colour = hnc_pkg::CLASS_ROCK;
      end else if (c1_ff >= SW'(16)) begin
         side2_in.colour = hnc_pkg::CLASS_GRASS;
      end else if (c1_ff >= -SW'(63)) begin
         side2_in.colour = hnc_pkg::CLASS_SAND;
      end else begin
         side2_in.colour = hnc_pkg::CLASS_DEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_ff   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
         az2_ff   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
         side2_ff <= side2_in;
      end
   end

   // Stage 3: squares
   always_ff @(posedge clock) begin
      if (en) begin
         sx3_ff   <= QW'(ax2_ff * ax2_ff);
         sz3_ff   <= QW'(az2_ff * az2_ff);
         side3_ff <= side2_ff;
      end
   end

   // Stage 4: S and the search targets a^2 * 2^30
   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff    <= hnc_pkg::S_W'(sx3_ff) + hnc_pkg::S_W'(sz3_ff)
                     + hnc_pkg::S_W'(hnc_pkg::Y_SQ);
         rx4_ff   <= {sx3_ff, 30'b0};
         rz4_ff   <= {sz3_ff, 30'b0};
         side4_ff <= side3_ff;
      end
   end

   assign ry4 = {hnc_pkg::Y_SQ, 30'b0};

   hnc_norm_lane u_lane_x (.clock(clock), .en(en), .s_in(s4_ff), .r_in(rx4_ff),
                           .mag_out(mag_x));
   hnc_norm_lane u_lane_y (.clock(clock), .en(en), .s_in(s4_ff), .r_in(ry4),
                           .mag_out(mag_y));
   hnc_norm_lane u_lane_z (.clock(clock), .en(en), .s_in(s4_ff), .r_in(rz4_ff),
                           .mag_out(mag_z));

   // Carry vertex data beside the search
   always_ff @(posedge clock) begin
      if (en) begin
         sidel_ff[0] <= side4_ff;
         for (int i = 1; i < STEPS; i++) begin
            sidel_ff[i] <= sidel_ff[i-1];
         end
      end
   end

   // Output: apply signs, water override, pack
   always_comb begin
      hnc_pkg::side_type      sd;
      logic [hnc_pkg::NORM_W-1:0] nx, nz;
      logic [hnc_pkg::MAG_W-1:0]  ny;
      logic [SW-1:0]              ht;
      logic [hnc_pkg::CLASS_W-1:0] cls;
      sd = sidel_ff[STEPS-1];
      nx = sd.neg_x ? -hnc_pkg::NORM_W'(mag_x) : hnc_pkg::NORM_W'(mag_x);
      nz = sd.neg_z ? -hnc_pkg::NORM_W'(mag_z) : hnc_pkg::NORM_W'(mag_z);
      ny = mag_y;
      ht = sd.height;
      cls = sd.colour;
      if (sd.water) begin
         nx  = '0;
         nz  = '0;
         ny  = hnc_pkg::UNIT_MAG;
         ht  = '0;
         cls = hnc_pkg::CLASS_WATER;
      end
      out_data_in = {cls, nz, ny, nx, ht, sd.row, sd.col};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
         out_last_ff <= sidel_ff[STEPS-1].last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> bench/heightmap_normal_colour_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_normal_colour_tb
// Streams height map rows through the normal and colour pipeline, predicts
// each vertex result (height, exact rounded unit normal, colour class, last
// marker) and compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module heightmap_normal_colour_tb;

   // Vertex result as carried on the result stream
   typedef struct {
      logic [hnc_pkg::COORD_W-1:0]  col;
      logic [hnc_pkg::COORD_W-1:0]  row;
      logic [hnc_pkg::SAMPLE_W-1:0] height;
      logic [hnc_pkg::NORM_W-1:0]   nx;
      logic [hnc_pkg::MAG_W-1:0]    ny;
      logic [hnc_pkg::NORM_W-1:0]   nz;
      logic [hnc_pkg::CLASS_W-1:0]  colour;
      logic                         last;
   } vertex_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_data = 1'b0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [hnc_pkg::SAMPLE_W-1:0]  req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [hnc_pkg::TDATA_W-1:0]   rsp_tdata;
   logic                          rsp_tlast;

   heightmap_normal_colour uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   // Predictor state
   logic [hnc_pkg::SAMPLE_W-1:0] older_row [hnc_pkg::MAP_W];
   logic [hnc_pkg::SAMPLE_W-1:0] newer_row [hnc_pkg::MAP_W];
   logic [hnc_pkg::SAMPLE_W-1:0] left_sample;
   int                  pos_col;
   int                  pos_row;
   logic                water_mode;

   vertex_type pending_vertices[$];
   int      fail_count;
   int      vertex_count;
   int      sample_count;
   int      water_vertices;
   logic    hold_off;
   int      gap_limit;

   // Rounded 16384*a/sqrt(s): largest m with (2m-1)^2 * s <= a^2 * 2^30
   function automatic logic [hnc_pkg::MAG_W-1:0] unit_mag(longint unsigned a,
                                                          longint unsigned s);
      longint unsigned lo, hi, mid, t, rhs;
      rhs = (a * a) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         if (t * t * s <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return hnc_pkg::MAG_W'(lo);
   endfunction

   function automatic logic [hnc_pkg::NORM_W-1:0] signed_unit(int v, longint unsigned s);
      logic [hnc_pkg::NORM_W-1:0] m;
      m = hnc_pkg::NORM_W'(unit_mag(v < 0 ? -v : v, s));
      return v < 0 ? -m : m;
   endfunction

   function automatic logic [hnc_pkg::CLASS_W-1:0] height_class(int h);
      int i;
      i = h / 16;
      if (i > 10) return hnc_pkg::CLASS_SNOW;
      if (i > 6) return hnc_pkg::CLASS_ROCK;
      if (i > 0) return hnc_pkg::CLASS_GRASS;
      if (i > -4) return hnc_pkg::CLASS_SAND;
      return hnc_pkg::CLASS_DEEP;
   endfunction

   // Advance the predictor by one accepted sample
   task automatic predict_sample(logic [hnc_pkg::SAMPLE_W-1:0] smp);
      vertex_type v;
      int centre, lft, rgt, up, dn, dx, dz;
      longint unsigned s;
      if (pos_row >= 2 && pos_col >= 1 && pos_col <= hnc_pkg::GRID_VERTS) begin
         centre = $signed(newer_row[pos_col]);
         lft = $signed(left_sample);
         rgt = $signed(newer_row[pos_col+1]);
         up = $signed(older_row[pos_col]);
         dn = $signed(smp);
         v.col = hnc_pkg::COORD_W'(pos_col - 1);
         v.row = hnc_pkg::COORD_W'(pos_row - 2);
         v.last = (pos_row == hnc_pkg::GRID_VERTS + 1 && pos_col == hnc_pkg::GRID_VERTS);
         if (water_mode) begin
            v.height = '0;
            v.nx = '0;
            v.ny = hnc_pkg::UNIT_MAG;
            v.nz = '0;
            v.colour = hnc_pkg::CLASS_WATER;
         end else begin
            dx = lft - rgt;
            dz = up - dn;
            s = longint'(dx) * dx + 1024 + longint'(dz) * dz;
            v.height = hnc_pkg::SAMPLE_W'(centre);
            v.nx = signed_unit(dx, s);
            v.ny = unit_mag(32, s);
            v.nz = signed_unit(dz, s);
            v.colour = height_class(centre);
         end
         pending_vertices.insert(pending_vertices.size(), v);
      end
      left_sample = newer_row[pos_col];
      older_row[pos_col] = newer_row[pos_col];
      newer_row[pos_col] = smp;
      pos_col++;
      if (pos_col >= hnc_pkg::MAP_W) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= hnc_pkg::MAP_W) pos_row = 0;
      end
   endtask

   // Send one sample and wait for its transfer
   task automatic send_sample(logic [hnc_pkg::SAMPLE_W-1:0] smp);
      int idle;
      idle = $urandom_range(0, gap_limit);
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_sample(smp);
      sample_count++;
   endtask

   task automatic write_water_mode(logic val);
      csr_valid <= 1'b1;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      water_mode = val;
      csr_valid <= 1'b0;
   endtask

   // Drain results, then let the pipeline settle before touching the register
   task automatic wait_idle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   // Random height with a bias toward small slopes and the class thresholds
   function automatic logic [hnc_pkg::SAMPLE_W-1:0] random_height();
      unique case ($urandom_range(0, 3))
         0: return hnc_pkg::SAMPLE_W'($urandom);
         1: return hnc_pkg::SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
         default: return hnc_pkg::SAMPLE_W'(int'($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   // Result check: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      vertex_type e;
      vertex_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.col = rsp_tdata[6:0];
         got.row = rsp_tdata[13:7];
         got.height = rsp_tdata[29:14];
         got.nx = rsp_tdata[45:30];
         got.ny = rsp_tdata[60:46];
         got.nz = rsp_tdata[76:61];
         got.colour = rsp_tdata[79:77];
         got.last = rsp_tlast;
         if (pending_vertices.size() == 0) begin
            $display("%0t unexpected vertex col %0d row %0d", $time, got.col, got.row);
            fail_count++;
         end else begin
            e = pending_vertices.pop_front();
            vertex_count++;
            if (e.colour == hnc_pkg::CLASS_WATER) water_vertices++;
            if (got.col !== e.col)
               $display("%0t col exp %0d got %0d", $time, e.col, got.col);
            if (got.row !== e.row)
               $display("%0t row exp %0d got %0d", $time, e.row, got.row);
            if (got.height !== e.height)
               $display("%0t height exp %h got %h", $time, e.height, got.height);
            if (got.nx !== e.nx)
               $display("%0t normal_x exp %h got %h", $time, e.nx, got.nx);
            if (got.ny !== e.ny)
               $display("%0t normal_y exp %h got %h", $time, e.ny, got.ny);
            if (got.nz !== e.nz)
               $display("%0t normal_z exp %h got %h", $time, e.nz, got.nz);
            if (got.colour !== e.colour)
               $display("%0t colour exp %0d got %0d", $time, e.colour, got.colour);
            if (got.last !== e.last)
               $display("%0t last exp %b got %b", $time, e.last, got.last);
            if (got.col !== e.col || got.row !== e.row || got.height !== e.height ||
                got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz ||
                got.colour !== e.colour || got.last !== e.last)
               fail_count++;
         end
      end
   end

   // Receiver: random stalls per transfer, with a long hold-off on request
   initial begin
      int wait_cycles;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         wait_cycles = (gap_limit == 0) ? 0 : $urandom_range(0, 11);
         if (wait_cycles == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // Opening rows of a frame: extremes, class thresholds, flat ground, varied
   task automatic test_directed_rows(int count);
      int i;
      logic [hnc_pkg::SAMPLE_W-1:0] h;
      gap_limit = 0;
      for (i = 0; i < count; i++) begin
         unique case (i % 25)
            0: h = 16'h7FFF;
            1: h = 16'h8000;
            2: h = 16'd176;   // 11.0: snow
            3: h = 16'd175;   // 10.9: rock
            4: h = 16'd112;   // 7.0 : rock
            5: h = 16'd111;   // grass
            6: h = 16'd16;    // grass
            7: h = 16'd15;    // truncates to 0: sand
            8: h = 16'hFFC1;  // -3.9: sand
            9: h = 16'hFFC0;  // -4.0: deep
            10: h = 16'hFFFF;
            11: h = 16'h0000;
            12: h = 16'h5555;
            13: h = 16'hAAAA;
            default: h = random_height();
         endcase
         send_sample(h);
      end
      wait_idle();
   endtask

   task automatic test_water_mode(int count);
      int i;
      write_water_mode(1'b1);
      gap_limit = 11;
      for (i = 0; i < count; i++) send_sample(random_height());
      wait_idle();
      write_water_mode(1'b0);
   endtask

   task automatic test_random_rows(int count, logic with_stall);
      int i;
      gap_limit = 11;
      for (i = 0; i < count; i++) begin
         if (with_stall && i == 20) hold_off = 1'b1;
         if (i % 100 == 0) gap_limit = $urandom_range(0, 1) ? 11 : 0;
         send_sample(random_height());
      end
      wait_idle();
   endtask

   initial begin
      pos_col = 0;
      pos_row = 0;
      left_sample = '0;
      water_mode = 1'b0;
      fail_count = 0;
      vertex_count = 0;
      sample_count = 0;
      water_vertices = 0;
      hold_off = 1'b0;
      gap_limit = 0;
      foreach (older_row[k]) begin
         older_row[k] = '0;
         newer_row[k] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_water_mode(1'b0);
      test_directed_rows(390);
      test_random_rows(260, 1'b1);
      test_water_mode(130);
      test_random_rows(270, 1'b0);
      if (pending_vertices.size() != 0) begin
         $display("%0t %0d vertices never arrived", $time, pending_vertices.size());
         fail_count++;
      end
      $display("%0d samples over the opening rows of a frame, %0d vertices checked",
               sample_count, vertex_count);
      $display("threshold and extreme heights, %0d water vertices, random gaps and a long hold-off",
               water_vertices);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end
endmodule

>>> filelist.f
sv/hnc_pkg.sv
sv/hnc_norm_lane.sv
sv/heightmap_normal_colour.sv
bench/heightmap_normal_colour_tb.sv
